[design/pmi_pkg.sv]
// shared types, codes and constants for the pmi substitution cost table
// no dependencies; imported by every module of the block
package pmi_pkg;

    localparam int DEF_MAX_SYMBOLS = 64;
    localparam int MAX_PATH_LEN    = 64;

    localparam int CFG_W   = 7;
    localparam int SYM_W   = 6;
    localparam int LEN_W   = 7;
    localparam int COST_W  = 17;
    localparam int CNT_W   = 32;
    localparam int LN_W    = 20;
    localparam int RAW_W   = 32;

    localparam logic [CNT_W-1:0]  ONE_Q16 = 32'h0001_0000;
    localparam logic [CNT_W-1:0]  CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0]       LN2_Q32 = 32'd2977044472;
    localparam logic [COST_W-1:0] COST_ONE = 17'h1_0000;

    typedef enum logic [1:0] {
        KIND_CLEAR    = 2'd0,
        KIND_ADD      = 2'd1,
        KIND_FINALIZE = 2'd2,
        KIND_READ     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [SYM_W-1:0]  sym_a;
        logic [SYM_W-1:0]  sym_b;
        logic [LEN_W-1:0]  path_len;
    } cmd_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        status_t           status;
    } result_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_NORM,
        LN_SQR,
        LN_FIX,
        LN_SCALE,
        LN_ROUND
    } ln_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } div_state_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_ADD_DIV,
        ST_ADD_PAIR,
        ST_ADD_SYMA,
        ST_ADD_SYMB,
        ST_FIN_STEP,
        ST_FIN_READ,
        ST_FIN_LNGO,
        ST_FIN_LNWAIT,
        ST_FIN_COST,
        ST_FIN_DIV,
        ST_READ_WAIT,
        ST_RESP
    } state_t;

endpackage

[design/pmi_ln_unit.sv]
// iterative natural log of an unsigned q16.16 value, result in q4.16
// one bit of normalization per cycle, then square and fix per bit; uses pmi_pkg
module pmi_ln_unit
    import pmi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] value,
    output logic             done,
    output logic [LN_W-1:0]  result
);

    ln_state_t         state_reg, state_next;
    logic [31:0]       x_reg;
    logic [4:0]        p_reg;
    logic [15:0]       frac_reg;
    logic [3:0]        step_reg;
    logic [63:0]       prod_reg;
    logic [31:0]       mul_a;
    logic [63:0]       round_sum;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LN_IDLE:  if (start) state_next = LN_NORM;
            LN_NORM:  if (x_reg[31]) state_next = LN_SQR;
            LN_SQR:   state_next = LN_FIX;
            LN_FIX:   state_next = (step_reg == 4'd15) ? LN_SCALE : LN_SQR;
            LN_SCALE: state_next = LN_ROUND;
            LN_ROUND: state_next = LN_IDLE;
            default:  state_next = LN_IDLE;
        endcase
    end

    // one shared multiplier: squaring, then scaling by ln 2
    assign mul_a     = (state_reg == LN_SCALE) ? {12'b0, p_reg[3:0], frac_reg} : x_reg;
    assign round_sum = prod_reg + 64'h0000_0000_8000_0000;
    assign done      = (state_reg == LN_ROUND);
    assign result    = round_sum[51:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            x_reg     <= '0;
            p_reg     <= '0;
            frac_reg  <= '0;
            step_reg  <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                LN_IDLE:
                begin
                    x_reg    <= (value[31:16] == 16'b0) ? ONE_Q16 : value;
                    p_reg    <= 5'd31;
                    frac_reg <= '0;
                    step_reg <= '0;
                end
                LN_NORM:
                begin
                    if (!x_reg[31])
                    begin
                        x_reg <= {x_reg[30:0], 1'b0};
                        p_reg <= p_reg - 5'd1;
                    end
                end
                LN_SQR:   prod_reg <= 64'(mul_a) * 64'(x_reg);
                LN_FIX:
                begin
                    // squared mantissa reached 2.0: take a one bit and halve
                    if (prod_reg[63])
                    begin
                        x_reg    <= prod_reg[63:32];
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        x_reg    <= prod_reg[62:31];
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                    step_reg <= step_reg + 4'd1;
                end
                LN_SCALE: prod_reg <= 64'(mul_a) * 64'(LN2_Q32);
                default:  prod_reg <= prod_reg;
            endcase
        end
    end

endmodule

[design/pmi_div_unit.sv]
// restoring divider for (num << 16) / den with num <= den, one quotient bit a cycle
// uses pmi_pkg; shared by the add weight and the cost normalization
module pmi_div_unit
    import pmi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       num,
    input  logic [31:0]       den,
    output logic              done,
    output logic [COST_W-1:0] quot
);

    div_state_t        state_reg, state_next;
    logic [32:0]       rem_reg;
    logic [31:0]       den_reg;
    logic [COST_W-1:0] q_reg;
    logic [4:0]        cnt_reg;
    logic [32:0]       shifted;
    logic              ge;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE: if (start) state_next = DV_RUN;
            DV_RUN:  if (cnt_reg == 5'd16) state_next = DV_DONE;
            DV_DONE: state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    // first step weighs the numerator at 2^16 itself, later ones shift in zeros
    assign shifted = (cnt_reg == 5'd0) ? rem_reg : {rem_reg[31:0], 1'b0};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign done    = (state_reg == DV_DONE);
    assign quot    = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DV_IDLE)
            begin
                rem_reg <= {1'b0, num};
                den_reg <= den;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            else if (state_reg == DV_RUN)
            begin
                rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
                q_reg   <= {q_reg[COST_W-2:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

endmodule

[design/pmi_substitution_cost_table.sv]
// top level: count and cost memories, command sequencer, shared ln and divide units
// depends on pmi_pkg, pmi_ln_unit and pmi_div_unit
//
// Each transaction is taken when start is high and busy is low, and gives one result,
// shown for a single cycle with done high; the receiver cannot stall it. After reset
// the block sweeps all MAX_SYMBOLS*(MAX_SYMBOLS+1)/2 pair entries (2080 at default)
// with busy high, setting counts to 1.0 and costs to zero. A clear sweeps the pair
// and symbol counts the same way but leaves the costs; an add runs a weight division,
// then a read-modify-write of the pair and two symbol counts through one port per
// memory; a read returns one stored cost. A finalize walks every pair below
// num_symbols twice, taking three logs per pair through one iterative ln unit, and on
// the second walk a division per pair unless all raw values are equal.
module pmi_substitution_cost_table
    import pmi_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    output logic             done,
    output result_t          result
);

    localparam int PAIR_DEPTH = MAX_SYMBOLS * (MAX_SYMBOLS + 1) / 2;
    localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
    localparam int SYM_AW     = $clog2(MAX_SYMBOLS);
    localparam int N_W        = ($clog2(MAX_SYMBOLS + 1) > CFG_W) ?
                                $clog2(MAX_SYMBOLS + 1) : CFG_W;
    localparam int TRI_W      = 2 * SYM_AW + 1;

    function automatic logic [PAIR_AW-1:0] tri_addr(input logic [SYM_AW-1:0] x,
                                                    input logic [SYM_AW-1:0] y);
        logic [SYM_AW-1:0] hi;
        logic [SYM_AW-1:0] lo;
        logic [TRI_W-1:0]  h;
        logic [TRI_W-1:0]  base;
        hi   = (x >= y) ? x : y;
        lo   = (x >= y) ? y : x;
        h    = TRI_W'(hi);
        base = (h * (h + TRI_W'(1))) >> 1;
        return PAIR_AW'(base + TRI_W'(lo));
    endfunction

    // memories
    logic [CNT_W-1:0]  pair_mem [PAIR_DEPTH];
    logic [CNT_W-1:0]  sym_mem  [MAX_SYMBOLS];
    logic [COST_W-1:0] cost_mem [PAIR_DEPTH];

    logic               pair_we, pair_re, sym_we, sym_re, cost_we, cost_re;
    logic [PAIR_AW-1:0] pair_wa, pair_ra, cost_wa, cost_ra;
    logic [SYM_AW-1:0]  sym_wa, sym_ra;
    logic [CNT_W-1:0]   pair_wd, sym_wd, pair_rd, sym_rd;
    logic [COST_W-1:0]  cost_wd, cost_rd;

    always_ff @(posedge clk)
    begin
        if (pair_we) pair_mem[pair_wa] <= pair_wd;
        if (pair_re) pair_rd <= pair_mem[pair_ra];
        if (sym_we)  sym_mem[sym_wa] <= sym_wd;
        if (sym_re)  sym_rd <= sym_mem[sym_ra];
        if (cost_we) cost_mem[cost_wa] <= cost_wd;
        if (cost_re) cost_rd <= cost_mem[cost_ra];
    end

    // registers
    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   num_sym_reg;
    logic [SYM_AW-1:0]  a_reg, a_next, b_reg, b_next;
    logic [PAIR_AW-1:0] idx_reg, idx_next, sweep_reg, sweep_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic [N_W-1:0]     r_reg, r_next, c_reg, c_next;
    logic               pass_reg, pass_next, any_reg, any_next;
    logic [1:0]         sel_reg, sel_next;
    logic [LN_W:0]      lsum_reg, lsum_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [RAW_W-1:0]   raw_min_reg, raw_min_next, raw_max_reg, raw_max_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    status_t            status_reg, status_next;

    // units
    logic               ln_start, ln_done, div_start, div_done;
    logic [CNT_W-1:0]   ln_value;
    logic [LN_W-1:0]    ln_result;
    logic [31:0]        div_num, div_den;
    logic [COST_W-1:0]  div_quot;

    pmi_ln_unit u_ln (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ln_start),
        .value  (ln_value),
        .done   (ln_done),
        .result (ln_result)
    );

    pmi_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // decode
    logic [N_W-1:0]     n_act, a_full, b_full;
    logic [SYM_AW-1:0]  a_idx, b_idx, r_idx, c_idx;
    logic               accept, sym_bad, len_bad;
    logic [RAW_W-1:0]   raw_now;
    logic [CNT_W:0]     sum_pair, sum_sym;
    logic [CNT_W-1:0]   sat_pair, sat_sym;

    assign n_act   = (N_W'(num_sym_reg) < N_W'(MAX_SYMBOLS)) ? N_W'(num_sym_reg)
                                                              : N_W'(MAX_SYMBOLS);
    assign a_full  = N_W'(cmd.sym_a);
    assign b_full  = N_W'(cmd.sym_b);
    assign a_idx   = a_full[SYM_AW-1:0];
    assign b_idx   = b_full[SYM_AW-1:0];
    assign r_idx   = r_reg[SYM_AW-1:0];
    assign c_idx   = c_reg[SYM_AW-1:0];
    assign accept  = start && (state_reg == ST_IDLE);
    assign sym_bad = (a_full >= n_act) || (b_full >= n_act);
    assign len_bad = (cmd.path_len == '0) || (32'(cmd.path_len) > 32'(MAX_PATH_LEN));
    assign raw_now = RAW_W'(lsum_reg) - RAW_W'(ln_result);

    assign sum_pair = {1'b0, pair_rd} + {1'b0, w_reg};
    assign sum_sym  = {1'b0, sym_rd} + {1'b0, w_reg};
    assign sat_pair = sum_pair[CNT_W] ? CNT_MAX : sum_pair[CNT_W-1:0];
    assign sat_sym  = sum_sym[CNT_W]  ? CNT_MAX : sum_sym[CNT_W-1:0];

    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_RESP);
    assign result.cost   = cost_reg;
    assign result.status = status_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (sweep_reg == PAIR_AW'(PAIR_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.kind)
                        KIND_CLEAR:    state_next = ST_CLEAR;
                        KIND_ADD:      state_next = (sym_bad || len_bad ||
                                                     cmd.sym_a == cmd.sym_b) ?
                                                    ST_RESP : ST_ADD_DIV;
                        KIND_FINALIZE: state_next = ST_FIN_STEP;
                        default:       state_next = (sym_bad || cmd.sym_a == cmd.sym_b) ?
                                                    ST_RESP : ST_READ_WAIT;
                    endcase
                end
            end
            ST_CLEAR:
                if (sweep_reg == PAIR_AW'(PAIR_DEPTH - 1)) state_next = ST_RESP;
            ST_ADD_DIV:    if (div_done) state_next = ST_ADD_PAIR;
            ST_ADD_PAIR:   state_next = ST_ADD_SYMA;
            ST_ADD_SYMA:   state_next = ST_ADD_SYMB;
            ST_ADD_SYMB:   state_next = ST_RESP;
            ST_FIN_STEP:
            begin
                if (r_reg == n_act)
                begin
                    if (pass_reg) state_next = ST_RESP;
                end
                else if (c_reg != r_reg)
                begin
                    state_next = ST_FIN_READ;
                end
            end
            ST_FIN_READ:   state_next = ST_FIN_LNGO;
            ST_FIN_LNGO:   state_next = ST_FIN_LNWAIT;
            ST_FIN_LNWAIT:
            begin
                if (ln_done)
                begin
                    if (sel_reg != 2'd2)  state_next = ST_FIN_READ;
                    else if (pass_reg)    state_next = ST_FIN_COST;
                    else                  state_next = ST_FIN_STEP;
                end
            end
            ST_FIN_COST:
                state_next = (raw_max_reg == raw_min_reg) ? ST_FIN_STEP : ST_FIN_DIV;
            ST_FIN_DIV:    if (div_done) state_next = ST_FIN_STEP;
            ST_READ_WAIT:  state_next = ST_RESP;
            ST_RESP:       state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        idx_next     = idx_reg;
        sweep_next   = sweep_reg;
        w_next       = w_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        pass_next    = pass_reg;
        any_next     = any_reg;
        sel_next     = sel_reg;
        lsum_next    = lsum_reg;
        raw_next     = raw_reg;
        raw_min_next = raw_min_reg;
        raw_max_next = raw_max_reg;
        cost_next    = cost_reg;
        status_next  = status_reg;

        pair_we = 1'b0;  pair_wa = idx_reg;  pair_wd = sat_pair;
        pair_re = 1'b0;  pair_ra = idx_reg;
        sym_we  = 1'b0;  sym_wa  = a_reg;    sym_wd  = sat_sym;
        sym_re  = 1'b0;  sym_ra  = a_reg;
        cost_we = 1'b0;  cost_wa = tri_addr(r_idx, c_idx);  cost_wd = div_quot;
        cost_re = 1'b0;  cost_ra = tri_addr(a_idx, b_idx);

        ln_start  = 1'b0;
        ln_value  = (sel_reg == 2'd2) ? pair_rd : sym_rd;
        div_start = 1'b0;
        div_num   = 32'd1;
        div_den   = 32'(cmd.path_len);

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                pair_we = 1'b1;
                pair_wa = sweep_reg;
                pair_wd = ONE_Q16;
                sym_we  = (32'(sweep_reg) < 32'(MAX_SYMBOLS));
                sym_wa  = SYM_AW'(sweep_reg);
                sym_wd  = ONE_Q16;
                cost_we = (state_reg == ST_INIT);
                cost_wa = sweep_reg;
                cost_wd = '0;
                sweep_next = (sweep_reg == PAIR_AW'(PAIR_DEPTH - 1)) ? '0
                                                                      : sweep_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_next      = a_idx;
                    b_next      = b_idx;
                    idx_next    = tri_addr(a_idx, b_idx);
                    cost_next   = '0;
                    status_next = STAT_DONE;
                    r_next      = '0;
                    c_next      = '0;
                    pass_next   = 1'b0;
                    any_next    = 1'b0;
                    case (cmd.kind)
                        KIND_ADD:
                        begin
                            if (sym_bad || len_bad)
                                status_next = STAT_RANGE;
                            else if (cmd.sym_a == cmd.sym_b)
                                status_next = STAT_IGNORED;
                            else
                                div_start = 1'b1;
                        end
                        KIND_READ:
                        begin
                            if (sym_bad)
                                status_next = STAT_RANGE;
                            else if (cmd.sym_a != cmd.sym_b)
                                cost_re = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_DIV:
            begin
                if (div_done)
                begin
                    w_next  = CNT_W'(div_quot);
                    pair_re = 1'b1;
                end
            end
            ST_ADD_PAIR:
            begin
                pair_we = 1'b1;
                sym_re  = 1'b1;
                sym_ra  = a_reg;
            end
            ST_ADD_SYMA:
            begin
                sym_we = 1'b1;
                sym_wa = a_reg;
                sym_re = 1'b1;
                sym_ra = b_reg;
            end
            ST_ADD_SYMB:
            begin
                sym_we = 1'b1;
                sym_wa = b_reg;
            end
            ST_FIN_STEP:
            begin
                if (r_reg == n_act)
                begin
                    if (!pass_reg)
                    begin
                        // first walk done: min and max are final, start writing costs
                        pass_next = 1'b1;
                        r_next    = '0;
                        c_next    = '0;
                        if (!any_reg)
                        begin
                            raw_min_next = '0;
                            raw_max_next = '0;
                        end
                    end
                end
                else if (c_reg == r_reg)
                begin
                    cost_we = pass_reg;
                    cost_wd = '0;
                    r_next  = r_reg + 1'b1;
                    c_next  = '0;
                end
                else
                begin
                    sel_next = 2'd0;
                end
            end
            ST_FIN_READ:
            begin
                case (sel_reg)
                    2'd0:
                    begin
                        sym_re = 1'b1;
                        sym_ra = r_idx;
                    end
                    2'd1:
                    begin
                        sym_re = 1'b1;
                        sym_ra = c_idx;
                    end
                    default:
                    begin
                        pair_re = 1'b1;
                        pair_ra = tri_addr(r_idx, c_idx);
                    end
                endcase
            end
            ST_FIN_LNGO:
                ln_start = 1'b1;
            ST_FIN_LNWAIT:
            begin
                if (ln_done)
                begin
                    case (sel_reg)
                        2'd0:    lsum_next = (LN_W + 1)'(ln_result);
                        2'd1:    lsum_next = lsum_reg + (LN_W + 1)'(ln_result);
                        default: raw_next  = raw_now;
                    endcase
                    sel_next = sel_reg + 2'd1;
                    if (sel_reg == 2'd2 && !pass_reg)
                    begin
                        any_next = 1'b1;
                        c_next   = c_reg + 1'b1;
                        if (!any_reg || $signed(raw_now) < $signed(raw_min_reg))
                            raw_min_next = raw_now;
                        if (!any_reg || $signed(raw_now) > $signed(raw_max_reg))
                            raw_max_next = raw_now;
                    end
                end
            end
            ST_FIN_COST:
            begin
                div_num = raw_reg - raw_min_reg;
                div_den = raw_max_reg - raw_min_reg;
                if (raw_max_reg == raw_min_reg)
                begin
                    cost_we = 1'b1;
                    cost_wd = COST_ONE;
                    c_next  = c_reg + 1'b1;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_FIN_DIV:
            begin
                if (div_done)
                begin
                    cost_we = 1'b1;
                    c_next  = c_reg + 1'b1;
                end
            end
            ST_READ_WAIT:
                cost_next = cost_rd;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            num_sym_reg <= CFG_W'(64);
            a_reg       <= '0;
            b_reg       <= '0;
            idx_reg     <= '0;
            sweep_reg   <= '0;
            w_reg       <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            pass_reg    <= 1'b0;
            any_reg     <= 1'b0;
            sel_reg     <= '0;
            lsum_reg    <= '0;
            raw_reg     <= '0;
            raw_min_reg <= '0;
            raw_max_reg <= '0;
            cost_reg    <= '0;
            status_reg  <= STAT_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we) num_sym_reg <= cfg_wdata;
            a_reg       <= a_next;
            b_reg       <= b_next;
            idx_reg     <= idx_next;
            sweep_reg   <= sweep_next;
            w_reg       <= w_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            pass_reg    <= pass_next;
            any_reg     <= any_next;
            sel_reg     <= sel_next;
            lsum_reg    <= lsum_next;
            raw_reg     <= raw_next;
            raw_min_reg <= raw_min_next;
            raw_max_reg <= raw_max_next;
            cost_reg    <= cost_next;
            status_reg  <= status_next;
        end
    end

endmodule
